>>> design/dhkv_pkg.sv
package dhkv_pkg;

   localparam int LOG2_SLOTS = 10;
   localparam int SLOT_W     = LOG2_SLOTS;
   localparam int SLOT_DEPTH = 1 << LOG2_SLOTS;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 4;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = COUNT_W;

   localparam logic [KEY_W-1:0]  KEY_EMPTY    = 32'hffff_ffff;
   localparam logic [KEY_W-1:0]  KEY_RESERVED = 32'hffff_fffe;
   localparam logic [31:0]       HASH_MUL     = 32'h9e37_79b1;
   localparam logic [SLOT_W-1:0] HASH_LO      = HASH_MUL[SLOT_W-1:0];

   localparam logic [SIZE_W-1:0]  SIZE_LOG2_RESET   = 4'd10;
   localparam logic [COUNT_W-1:0] ENTRY_LIMIT_RESET = 11'd768;

   localparam logic CSR_SIZE_LOG2   = 1'b0;
   localparam logic CSR_ENTRY_LIMIT = 1'b1;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_PUT    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_RESERVED = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] value_out;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      RSP_NONE     = 3'd0,
      RSP_RESERVED = 3'd1,
      RSP_HIT      = 3'd2,
      RSP_MISS     = 3'd3,
      RSP_FULL     = 3'd4
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         clear_start;
      logic         clear_wr;
      logic         probe_rd;
      logic         advance;
      logic         write_key;
      logic         write_val;
      logic         count_inc;
      logic         load_rsp;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       req_reserved;
      logic       hit;
      logic       empty;
      logic       last_probe;
      logic       room;
      logic       clear_last;
      logic       rsp_busy;
   } stat_type;

endpackage

>>> design/dhkv_dp.sv
module dhkv_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  dhkv_pkg::cmd_type               cmd,
   output dhkv_pkg::stat_type              stat,
   input  dhkv_pkg::req_type               req_payload,
   input  logic [dhkv_pkg::SLOT_W-1:0]     mask,
   input  logic [dhkv_pkg::COUNT_W-1:0]    entry_limit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dhkv_pkg::rsp_type               rsp_payload
);

   logic [dhkv_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [dhkv_pkg::VALUE_W-1:0] vin_ff, vin_in;
   logic [dhkv_pkg::SLOT_W-1:0]  pos_ff, pos_in;
   logic [dhkv_pkg::SLOT_W-1:0]  step_ff, step_in;
   logic [dhkv_pkg::SLOT_W-1:0]  n_ff, n_in;
   logic [dhkv_pkg::SLOT_W-1:0]  clr_ff, clr_in;
   logic [dhkv_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dhkv_pkg::rsp_type            rsp_ff, rsp_in;

   logic [dhkv_pkg::KEY_W-1:0]   key_mem [dhkv_pkg::SLOT_DEPTH];
   logic [dhkv_pkg::VALUE_W-1:0] val_mem [dhkv_pkg::SLOT_DEPTH];
   logic [dhkv_pkg::KEY_W-1:0]   rd_key_ff;
   logic [dhkv_pkg::VALUE_W-1:0] rd_val_ff;

   logic                         key_we;
   logic [dhkv_pkg::SLOT_W-1:0]  key_waddr;
   logic [dhkv_pkg::KEY_W-1:0]   key_wdata;
   logic [dhkv_pkg::SLOT_W-1:0]  req_key_lo;

   assign req_key_lo = req_payload.key[dhkv_pkg::SLOT_W-1:0];

   always_comb begin
      key_in  = key_ff;
      vin_in  = vin_ff;
      pos_in  = pos_ff;
      step_in = step_ff;
      n_in    = n_ff;
      if (cmd.load_req) begin
         key_in  = req_payload.key;
         vin_in  = req_payload.value_in;
         pos_in  = (req_key_lo * dhkv_pkg::HASH_LO) & mask;
         step_in = (req_key_lo | dhkv_pkg::SLOT_W'(1)) & mask;
         n_in    = '0;
      end else if (cmd.advance) begin
         pos_in = (pos_ff + step_ff) & mask;
         n_in   = n_ff + dhkv_pkg::SLOT_W'(1);
      end
   end

   always_comb begin
      clr_in   = clr_ff;
      count_in = count_ff;
      if (cmd.clear_start) begin
         clr_in   = '0;
         count_in = '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_in = clr_ff + dhkv_pkg::SLOT_W'(1);
         end
         if (cmd.count_inc) begin
            count_in = count_ff + dhkv_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      vin_ff  <= vin_in;
      pos_ff  <= pos_in;
      step_ff <= step_in;
      n_ff    <= n_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   assign key_we    = cmd.clear_wr | cmd.write_key;
   assign key_waddr = cmd.clear_wr ? clr_ff : pos_ff;
   assign key_wdata = cmd.clear_wr ? dhkv_pkg::KEY_EMPTY : key_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      if (cmd.probe_rd) begin
         rd_key_ff <= key_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_val) begin
         val_mem[pos_ff] <= vin_ff;
      end
      if (cmd.probe_rd) begin
         rd_val_ff <= val_mem[pos_ff];
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         case (cmd.rsp_kind)
            dhkv_pkg::RSP_RESERVED: begin
               rsp_in.found     = 1'b0;
               rsp_in.value_out = '0;
               rsp_in.status    = dhkv_pkg::STATUS_RESERVED;
            end
            dhkv_pkg::RSP_HIT: begin
               rsp_in.found     = 1'b1;
               rsp_in.value_out = rd_val_ff;
               rsp_in.status    = dhkv_pkg::STATUS_OK;
            end
            dhkv_pkg::RSP_MISS: begin
               rsp_in.found     = 1'b0;
               rsp_in.value_out = vin_ff;
               rsp_in.status    = dhkv_pkg::STATUS_OK;
            end
            dhkv_pkg::RSP_FULL: begin
               rsp_in.found     = 1'b0;
               rsp_in.value_out = vin_ff;
               rsp_in.status    = dhkv_pkg::STATUS_FULL;
            end
            default: begin
               rsp_in.found     = 1'b0;
               rsp_in.value_out = '0;
               rsp_in.status    = dhkv_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      stat.req_op       = req_payload.operation;
      stat.req_reserved = (req_payload.key == dhkv_pkg::KEY_EMPTY) ||
                          (req_payload.key == dhkv_pkg::KEY_RESERVED);
      stat.hit          = (rd_key_ff == key_ff);
      stat.empty        = (rd_key_ff == dhkv_pkg::KEY_EMPTY);
      stat.last_probe   = (n_ff == mask);
      stat.room         = (count_ff < entry_limit);
      stat.clear_last   = (clr_ff == {dhkv_pkg::SLOT_W{1'b1}});
      stat.rsp_busy     = rsp_valid_ff & rsp_stall;
   end

endmodule

>>> design/dhkv_ctrl.sv
module dhkv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dhkv_pkg::stat_type  stat,
   output dhkv_pkg::cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_CHECK = 5'b00100,
      S_CLEAR = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic                   reply_ff, reply_in;
   logic                   is_put_ff, is_put_in;
   dhkv_pkg::rsp_kind_type kind_ff, kind_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      reply_in  = reply_ff;
      is_put_in = is_put_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      cmd.rsp_kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               is_put_in    = (stat.req_op == dhkv_pkg::OP_PUT);
               case (stat.req_op)
                  dhkv_pkg::OP_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     reply_in        = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  dhkv_pkg::OP_LOOKUP, dhkv_pkg::OP_PUT: begin
                     if (stat.req_reserved) begin
                        kind_in  = dhkv_pkg::RSP_RESERVED;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     kind_in  = dhkv_pkg::RSP_NONE;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.probe_rd = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (stat.hit) begin
               kind_in       = dhkv_pkg::RSP_HIT;
               cmd.write_val = is_put_ff;
               state_in      = S_RESP;
            end else if (stat.empty) begin
               state_in = S_RESP;
               if (!is_put_ff) begin
                  kind_in = dhkv_pkg::RSP_MISS;
               end else if (stat.room) begin
                  kind_in       = dhkv_pkg::RSP_MISS;
                  cmd.write_key = 1'b1;
                  cmd.write_val = 1'b1;
                  cmd.count_inc = 1'b1;
               end else begin
                  kind_in = dhkv_pkg::RSP_FULL;
               end
            end else if (stat.last_probe) begin
               kind_in  = is_put_ff ? dhkv_pkg::RSP_FULL : dhkv_pkg::RSP_MISS;
               state_in = S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               kind_in  = dhkv_pkg::RSP_NONE;
               state_in = reply_ff ? S_RESP : S_IDLE;
               reply_in = 1'b0;
            end
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         reply_ff  <= 1'b0;
         is_put_ff <= 1'b0;
         kind_ff   <= dhkv_pkg::RSP_NONE;
      end else begin
         state_ff  <= state_in;
         reply_ff  <= reply_in;
         is_put_ff <= is_put_in;
         kind_ff   <= kind_in;
      end
   end

endmodule

>>> design/double_hash_key_value_table.sv
// Order: lookup and put pass a read and a check state per probe, then the response state,
// which waits while the previous result is held; reserved keys and no-ops go straight there.
// Throughput: one item at a time; each probe is one read of the key and value memories.
// Clear sweeps every slot of the key memory, then answers.
// Reset: synchronous; after reset the key memory is swept empty, during which no item is taken.
// Configuration registers return to 10 and 768.
module double_hash_key_value_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dhkv_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dhkv_pkg::rsp_type             rsp_payload,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [dhkv_pkg::CSR_W-1:0]    csr_data
);

   logic [dhkv_pkg::SIZE_W-1:0]  size_log2_ff, size_log2_in;
   logic [dhkv_pkg::COUNT_W-1:0] entry_limit_ff, entry_limit_in;
   logic [dhkv_pkg::SLOT_W-1:0]  mask;
   dhkv_pkg::cmd_type            cmd;
   dhkv_pkg::stat_type           stat;

   always_comb begin
      size_log2_in   = size_log2_ff;
      entry_limit_in = entry_limit_ff;
      if (csr_write) begin
         case (csr_index)
            dhkv_pkg::CSR_SIZE_LOG2:   size_log2_in   = csr_data[dhkv_pkg::SIZE_W-1:0];
            dhkv_pkg::CSR_ENTRY_LIMIT: entry_limit_in = csr_data[dhkv_pkg::COUNT_W-1:0];
            default: begin
               size_log2_in   = size_log2_ff;
               entry_limit_in = entry_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff   <= dhkv_pkg::SIZE_LOG2_RESET;
         entry_limit_ff <= dhkv_pkg::ENTRY_LIMIT_RESET;
      end else begin
         size_log2_ff   <= size_log2_in;
         entry_limit_ff <= entry_limit_in;
      end
   end

   assign mask = (32'(size_log2_ff) >= dhkv_pkg::LOG2_SLOTS) ?
                 {dhkv_pkg::SLOT_W{1'b1}} :
                 ~({dhkv_pkg::SLOT_W{1'b1}} << size_log2_ff);

   dhkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dhkv_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .mask        (mask),
      .entry_limit (entry_limit_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> sim/double_hash_key_value_table_checker.sv
module double_hash_key_value_table_checker
   import dhkv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_type            req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_type            rsp_payload,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_data,
   output int                 mismatches,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [KEY_W-1:0]   slot_key [SLOT_DEPTH];
   logic [VALUE_W-1:0] slot_val [SLOT_DEPTH];
   logic [COUNT_W-1:0] entry_count;
   logic [SIZE_W-1:0]  size_log2;
   logic [COUNT_W-1:0] entry_limit;
   rsp_type            due_answers [$];

   function automatic rsp_type apply_table_op(input req_type item);
      rsp_type           answer;
      logic [SIZE_W-1:0] eff;
      logic [SLOT_W-1:0] mask;
      logic [SLOT_W-1:0] step;
      logic [SLOT_W-1:0] pos;
      logic [31:0]       product;
      logic              slot_ok;
      logic              hit;
      answer = '0;
      answer.status = STATUS_OK;
      case (item.operation)
         OP_CLEAR: begin
            for (int i = 0; i < SLOT_DEPTH; i++) slot_key[i] = KEY_EMPTY;
            entry_count = '0;
         end
         OP_LOOKUP, OP_PUT: begin
            if (item.key == KEY_EMPTY || item.key == KEY_RESERVED) begin
               answer.status = STATUS_RESERVED;
            end else begin
               eff = (size_log2 > LOG2_SLOTS) ? SIZE_W'(LOG2_SLOTS) : size_log2;
               mask = SLOT_W'((1 << eff) - 1);
               step = (item.key[SLOT_W-1:0] | 1'b1) & mask;
               product = item.key * HASH_MUL;
               pos = product[SLOT_W-1:0] & mask;
               slot_ok = 1'b0;
               for (int n = 0; n <= int'(mask) && !slot_ok; n++) begin
                  if (slot_key[pos] == item.key || slot_key[pos] == KEY_EMPTY) begin
                     slot_ok = 1'b1;
                  end else begin
                     pos = (pos + step) & mask;
                  end
               end
               hit = slot_ok && slot_key[pos] == item.key;
               if (hit) begin
                  answer.found = 1'b1;
                  answer.value_out = slot_val[pos];
                  if (item.operation == OP_PUT) slot_val[pos] = item.value_in;
               end else begin
                  answer.value_out = item.value_in;
                  if (item.operation == OP_PUT) begin
                     if (slot_ok && entry_count < entry_limit) begin
                        slot_key[pos] = item.key;
                        slot_val[pos] = item.value_in;
                        entry_count = entry_count + 1'b1;
                     end else begin
                        answer.status = STATUS_FULL;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_DEPTH; i++) begin
            slot_key[i] = KEY_EMPTY;
            slot_val[i] = '0;
         end
         entry_count = '0;
         size_log2 = SIZE_LOG2_RESET;
         entry_limit = ENTRY_LIMIT_RESET;
         due_answers.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected transfer found=%0d value_out=%h status=%0d",
                           $realtime, rsp_payload.found, rsp_payload.value_out,
                           rsp_payload.status);
            end else begin
               want = due_answers.pop_front();
               if (want.found !== rsp_payload.found ||
                   want.value_out !== rsp_payload.value_out ||
                   want.status !== rsp_payload.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected found=%0d value_out=%h status=%0d, ",
                              $realtime, want.found, want.value_out, want.status,
                              "got found=%0d value_out=%h status=%0d",
                              rsp_payload.found, rsp_payload.value_out, rsp_payload.status);
               end
            end
         end
         if (csr_write) begin
            if (csr_index == CSR_SIZE_LOG2) size_log2 = csr_data[SIZE_W-1:0];
            else entry_limit = csr_data[COUNT_W-1:0];
         end
         if (req_valid && !req_stall) due_answers.push_back(apply_table_op(req_payload));
      end
      outstanding = due_answers.size();
   end

endmodule

>>> sim/tb_double_hash_key_value_table.sv
module tb_double_hash_key_value_table;
   timeunit 1ns;
   timeprecision 1ps;
   import dhkv_pkg::*;

   localparam logic [1:0] OP_IDLE     = 2'd3;
   localparam int         CYCLE_LIMIT = 3_000_000;
   localparam int         PHASE_ITEMS = 136;
   localparam int         POOL_SIZE   = 24;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_payload;
   logic             csr_write;
   logic             csr_index;
   logic [CSR_W-1:0] csr_data;
   int               mismatches;
   int               outstanding;
   int               sender_idle;
   int               receiver_idle;
   int               cycles;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   double_hash_key_value_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   double_hash_key_value_table_checker u_table_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("double_hash_key_value_table test failed");
         $finish;
      end
   end

   function automatic req_type make_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] data);
      req_type item;
      item.operation = op;
      item.key = key;
      item.value_in = data;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) item.operation = OP_LOOKUP;
      else if (pick < 93) item.operation = OP_PUT;
      else if (pick < 96) item.operation = OP_CLEAR;
      else item.operation = OP_IDLE;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         item.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 92) begin
         item.key = $urandom;
      end else begin
         case ($urandom_range(0, 5))
            0: item.key = '0;
            1: item.key = 32'h7fff_ffff;
            2: item.key = 32'h8000_0000;
            3: item.key = 32'hffff_fffd;
            4: item.key = KEY_RESERVED;
            default: item.key = KEY_EMPTY;
         endcase
      end
      item.value_in = $urandom;
      return item;
   endfunction

   // hold the payload until the transfer; the caller raises valid again or drops it
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(input logic index, input logic [CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_table(input int size, input int limit);
      drain();
      write_csr(CSR_SIZE_LOG2, CSR_W'(size));
      write_csr(CSR_ENTRY_LIMIT, CSR_W'(limit));
   endtask

   initial begin
      int size;
      int limit;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_stall <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= CSR_SIZE_LOG2;
      csr_data <= '0;
      sender_idle = 16;
      receiver_idle = 78;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(make_item(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff));
      send_item(make_item(OP_PUT, 32'h0000_0000, 32'h1234_5678));
      send_item(make_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
      send_item(make_item(OP_PUT, 32'h0000_0000, 32'hdead_beef));
      send_item(make_item(OP_PUT, KEY_EMPTY, 32'h5555_5555));
      send_item(make_item(OP_LOOKUP, KEY_RESERVED, 32'haaaa_aaaa));
      send_item(make_item(OP_PUT, KEY_RESERVED, 32'h0000_0001));
      send_item(make_item(OP_LOOKUP, KEY_EMPTY, 32'h0000_0002));
      send_item(make_item(OP_PUT, 32'hffff_fffd, 32'hffff_ffff));
      send_item(make_item(OP_PUT, 32'h8000_0000, 32'h0000_0000));
      send_item(make_item(OP_LOOKUP, 32'hffff_fffd, 32'h0000_0000));
      send_item(make_item(OP_IDLE, $urandom, $urandom));
      send_item(make_item(OP_CLEAR, $urandom, $urandom));
      send_item(make_item(OP_LOOKUP, 32'h0000_0000, 32'h0bad_cafe));

      // single slot: fill it, then hit the limit and the probe bound
      set_table(0, 1);
      send_item(make_item(OP_PUT, 32'h0000_0005, 32'h1111_1111));
      send_item(make_item(OP_PUT, 32'h0000_0006, 32'h2222_2222));
      send_item(make_item(OP_LOOKUP, 32'h0000_0006, 32'h3333_3333));
      set_table(0, 1024);
      send_item(make_item(OP_PUT, 32'h0000_0006, 32'h4444_4444));
      send_item(make_item(OP_LOOKUP, 32'h0000_0005, 32'h0000_0000));
      set_table(15, 0);
      send_item(make_item(OP_PUT, 32'h0000_0007, 32'h6666_6666));
      send_item(make_item(OP_LOOKUP, 32'h0000_0005, 32'h7777_7777));
      send_item(make_item(OP_CLEAR, 32'h0000_0000, 32'h0000_0000));
      send_item(make_item(OP_PUT, 32'h0000_0008, 32'h8888_8888));

      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin size = 10; limit = 768; end
            1: begin size = 0; limit = 1024; end
            2: begin size = 1; limit = 2; end
            3: begin size = 2; limit = 1024; end
            4: begin size = 15; limit = 1024; end
            5: begin size = 3; limit = 0; end
            6: begin size = 4; limit = 9; end
            7: begin size = 10; limit = 1024; end
            8: begin size = 5; limit = 40; end
            9: begin size = 8; limit = 100; end
            10: begin size = 12; limit = 1024; end
            default: begin size = 6; limit = 12; end
         endcase
         if (phase == 4) begin
            sender_idle = 78;
            receiver_idle = 16;
         end else if (phase == 8) begin
            sender_idle = 0;
            receiver_idle = 0;
         end
         set_table(size, limit);
         for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
         repeat (PHASE_ITEMS) send_item(random_item());
      end
      drain();
      repeat (64) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("double_hash_key_value_table test passed");
      end else begin
         $display("double_hash_key_value_table test failed");
      end
      $finish;
   end

endmodule
